[sv/psd3_pkg.sv]
package psd3_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int T_FRAC_BITS_DEF = 24;
  localparam int DIST_WIDTH      = 25;

  typedef enum logic [1:0] {
    TM_ZERO,
    TM_ONE,
    TM_DIV
  } tmode_t;

  typedef struct packed {
    logic valid;
    logic degen;
  } psd3_ctl_t;

endpackage

[sv/psd3_if.sv]
interface psd3_in_if #(
  parameter int CW = 24
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] p_x;
  logic signed [CW-1:0] p_y;
  logic signed [CW-1:0] p_z;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;

  modport source (output valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
                output ready);
endinterface

interface psd3_out_if #(
  parameter int DW = 25
) ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] distance;
  logic          segment_degenerate;

  modport source (output valid, distance, segment_degenerate, input ready);
  modport sink (input valid, distance, segment_degenerate, output ready);
endinterface

[sv/psd3_front.sv]
module psd3_front
  import psd3_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  localparam int DW = CW + 1,
  localparam int PW = 2 * DW,
  localparam int DOTW = PW + 1,
  localparam int LENW = PW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] p_i [3],
  input  logic signed [CW-1:0] a_i [3],
  input  logic signed [CW-1:0] b_i [3],
  output psd3_ctl_t            ctl_o,
  output tmode_t               mode_o,
  output logic signed [DW-1:0] ap_o [3],
  output logic signed [DW-1:0] ab_o [3],
  output logic [LENW-1:0]      rem_o,
  output logic [LENW-1:0]      den_o
);

  logic                 v1_r, v2_r;
  psd3_ctl_t            ctl3_r;
  logic signed [DW-1:0] ap1_r [3], ab1_r [3], ap2_r [3], ab2_r [3], ap3_r [3], ab3_r [3];
  logic signed [PW-1:0] mdot_r [3], mlen_r [3];
  tmode_t               mode3_r, mode_nxt;
  logic [LENW-1:0]      rem3_r, den3_r, rem_nxt, len_nxt;
  logic signed [DOTW-1:0] dot_nxt;
  logic                 degen_nxt;

  always_comb begin
    dot_nxt = DOTW'(mdot_r[0]) + DOTW'(mdot_r[1]) + DOTW'(mdot_r[2]);
    len_nxt = $unsigned(mlen_r[0]) + $unsigned(mlen_r[1]) + $unsigned(mlen_r[2]);
    degen_nxt = (len_nxt == '0);
    if (degen_nxt || dot_nxt <= 0) begin
      mode_nxt = TM_ZERO;
    end else if (dot_nxt >= $signed({1'b0, len_nxt})) begin
      mode_nxt = TM_ONE;
    end else begin
      mode_nxt = TM_DIV;
    end
    rem_nxt = (mode_nxt == TM_DIV) ? dot_nxt[LENW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
    end else if (en) begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      ctl3_r.valid <= v2_r;
      ctl3_r.degen <= degen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ap1_r[i]  <= DW'(p_i[i]) - DW'(a_i[i]);
        ab1_r[i]  <= DW'(b_i[i]) - DW'(a_i[i]);
        ap2_r[i]  <= ap1_r[i];
        ab2_r[i]  <= ab1_r[i];
        mdot_r[i] <= ap1_r[i] * ab1_r[i];
        mlen_r[i] <= ab1_r[i] * ab1_r[i];
        ap3_r[i]  <= ap2_r[i];
        ab3_r[i]  <= ab2_r[i];
      end
      mode3_r <= mode_nxt;
      rem3_r  <= rem_nxt;
      den3_r  <= len_nxt;
    end
  end

  assign ctl_o  = ctl3_r;
  assign mode_o = mode3_r;
  assign ap_o   = ap3_r;
  assign ab_o   = ab3_r;
  assign rem_o  = rem3_r;
  assign den_o  = den3_r;

endmodule

[sv/psd3_div.sv]
module psd3_div
  import psd3_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int T  = T_FRAC_BITS_DEF,
  localparam int DW = CW + 1,
  localparam int LENW = 2 * DW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  psd3_ctl_t            ctl_i,
  input  tmode_t               mode_i,
  input  logic signed [DW-1:0] ap_i [3],
  input  logic signed [DW-1:0] ab_i [3],
  input  logic [LENW-1:0]      rem_i,
  input  logic [LENW-1:0]      den_i,
  output psd3_ctl_t            ctl_o,
  output logic signed [DW-1:0] ap_o [3],
  output logic signed [DW-1:0] ab_o [3],
  output logic [T:0]           t_o
);

  psd3_ctl_t            ctl_r [T];
  tmode_t               mode_r [T];
  logic signed [DW-1:0] ap_r [T][3];
  logic signed [DW-1:0] ab_r [T][3];
  logic [LENW-1:0]      rem_r [T], den_r [T];
  logic [T-1:0]         q_r [T];

  psd3_ctl_t            ctl_s [T];
  tmode_t               mode_s [T];
  logic signed [DW-1:0] ap_s [T][3];
  logic signed [DW-1:0] ab_s [T][3];
  logic [LENW-1:0]      rem_s [T], den_s [T], rem_nxt [T];
  logic [T-1:0]         q_s [T], q_nxt [T];
  logic [LENW:0]        r2 [T];
  logic                 ge [T];

  always_comb begin
    for (int k = 0; k < T; k++) begin
      if (k == 0) begin
        ctl_s[k]  = ctl_i;
        mode_s[k] = mode_i;
        ap_s[k]   = ap_i;
        ab_s[k]   = ab_i;
        rem_s[k]  = rem_i;
        den_s[k]  = den_i;
        q_s[k]    = '0;
      end else begin
        ctl_s[k]  = ctl_r[k-1];
        mode_s[k] = mode_r[k-1];
        ap_s[k]   = ap_r[k-1];
        ab_s[k]   = ab_r[k-1];
        rem_s[k]  = rem_r[k-1];
        den_s[k]  = den_r[k-1];
        q_s[k]    = q_r[k-1];
      end
      r2[k]      = {rem_s[k], 1'b0};
      ge[k]      = (r2[k] >= {1'b0, den_s[k]});
      rem_nxt[k] = ge[k] ? LENW'(r2[k] - {1'b0, den_s[k]}) : r2[k][LENW-1:0];
      q_nxt[k]   = {q_s[k][T-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < T; k++) ctl_r[k] <= '0;
    end else if (en) begin
      for (int k = 0; k < T; k++) ctl_r[k] <= ctl_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < T; k++) begin
        mode_r[k] <= mode_s[k];
        ap_r[k]   <= ap_s[k];
        ab_r[k]   <= ab_s[k];
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_s[k];
        q_r[k]    <= q_nxt[k];
      end
    end
  end

  always_comb begin
    unique case (mode_r[T-1])
      TM_ONE:  t_o = {1'b1, {T{1'b0}}};
      TM_DIV:  t_o = {1'b0, q_r[T-1]};
      default: t_o = '0;
    endcase
  end

  assign ctl_o = ctl_r[T-1];
  assign ap_o  = ap_r[T-1];
  assign ab_o  = ab_r[T-1];

endmodule

[sv/psd3_proj.sv]
module psd3_proj
  import psd3_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int T  = T_FRAC_BITS_DEF,
  localparam int DW = CW + 1,
  localparam int DDW = DW + T + 2,
  localparam int MW = DW + T + 1,
  localparam int HW = (MW + 1) / 2,
  localparam int HIW = MW - HW,
  localparam int SQW = 2 * MW,
  localparam int SW = SQW + 2,
  localparam int RW = SW - 2 * T
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  psd3_ctl_t            ctl_i,
  input  logic signed [DW-1:0] ap_i [3],
  input  logic signed [DW-1:0] ab_i [3],
  input  logic [T:0]           t_i,
  output psd3_ctl_t            ctl_o,
  output logic [RW-1:0]        x_o
);

  psd3_ctl_t             ctla_r, ctlb_r, ctlc_r, ctld_r, ctle_r;
  logic signed [DW-1:0]  apa_r [3];
  logic signed [DDW-1:0] prod_r [3], d_nxt [3];
  logic [MW-1:0]         mag_r [3], mag_nxt [3];
  logic [2*HIW-1:0]      hh_r [3];
  logic [HIW+HW-1:0]     hl_r [3];
  logic [2*HW-1:0]       ll_r [3];
  logic [SQW-1:0]        sq_r [3];
  logic [SW-1:0]         sum_nxt;
  logic [RW-1:0]         x_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i]   = (DDW'(apa_r[i]) <<< T) - prod_r[i];
      mag_nxt[i] = d_nxt[i][DDW-1] ? MW'(-d_nxt[i]) : MW'(d_nxt[i]);
    end
    sum_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r <= '0;
      ctlb_r <= '0;
      ctlc_r <= '0;
      ctld_r <= '0;
      ctle_r <= '0;
    end else if (en) begin
      ctla_r <= ctl_i;
      ctlb_r <= ctla_r;
      ctlc_r <= ctlb_r;
      ctld_r <= ctlc_r;
      ctle_r <= ctld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        apa_r[i]  <= ap_i[i];
        prod_r[i] <= ab_i[i] * $signed({1'b0, t_i});
        mag_r[i]  <= mag_nxt[i];
        hh_r[i]   <= mag_r[i][MW-1:HW] * mag_r[i][MW-1:HW];
        hl_r[i]   <= mag_r[i][MW-1:HW] * mag_r[i][HW-1:0];
        ll_r[i]   <= mag_r[i][HW-1:0] * mag_r[i][HW-1:0];
        sq_r[i]   <= (SQW'(hh_r[i]) << (2 * HW)) + (SQW'(hl_r[i]) << (HW + 1))
                     + SQW'(ll_r[i]);
      end
      x_r <= sum_nxt[SW-1:2*T];
    end
  end

  assign ctl_o = ctle_r;
  assign x_o   = x_r;

endmodule

[sv/psd3_sqrt.sv]
module psd3_sqrt
  import psd3_pkg::*;
#(
  parameter int RW = 54,
  localparam int QW = (RW + 1) / 2,
  localparam int XW = 2 * QW,
  localparam int RMW = QW + 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  psd3_ctl_t     ctl_i,
  input  logic [RW-1:0] x_i,
  output psd3_ctl_t     ctl_o,
  output logic [QW-1:0] root_o
);

  psd3_ctl_t      ctl_r [QW], ctl_s [QW];
  logic [XW-1:0]  x_r [QW], x_s [QW];
  logic [RMW-1:0] rem_r [QW], rem_s [QW], rem_nxt [QW], sh [QW], trial [QW];
  logic [QW-1:0]  q_r [QW], q_s [QW], q_nxt [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        ctl_s[k] = ctl_i;
        x_s[k]   = XW'(x_i);
        rem_s[k] = '0;
        q_s[k]   = '0;
      end else begin
        ctl_s[k] = ctl_r[k-1];
        x_s[k]   = x_r[k-1];
        rem_s[k] = rem_r[k-1];
        q_s[k]   = q_r[k-1];
      end
      sh[k]    = {rem_s[k][RMW-3:0], x_s[k][XW-1:XW-2]};
      trial[k] = RMW'({q_s[k], 2'b01});
      if (sh[k] >= trial[k]) begin
        rem_nxt[k] = sh[k] - trial[k];
        q_nxt[k]   = {q_s[k][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[k];
        q_nxt[k]   = {q_s[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) ctl_r[k] <= '0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) ctl_r[k] <= ctl_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        x_r[k]   <= {x_s[k][XW-3:0], 2'b00};
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign ctl_o  = ctl_r[QW-1];
  assign root_o = q_r[QW-1];

endmodule

[sv/point_segment_distance_3d_core.sv]
// Channel  Direction  Transaction payload
// in_if    sink       p_x p_y p_z a_x a_y a_z b_x b_y b_z (signed, COORD_WIDTH each)
// out_if   source     distance (DIST_WIDTH), segment_degenerate
//
// One transaction per cycle in and out while no result waits with out_if.ready low.
// Pipeline: front end, divider, projection, square root; the divider and square root
// resolve one bit per stage.
// Reset clears the stage control bits (valid and degenerate flags) only.
// The whole pipeline holds while a result waits and out_if.ready is low.
module point_segment_distance_3d_core
  import psd3_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  psd3_in_if.sink    in_if,
  psd3_out_if.source out_if
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int LENW = 2 * DW;
  localparam int MW   = DW + T_FRAC_BITS + 1;
  localparam int RW   = 2 * MW + 2 - 2 * T_FRAC_BITS;
  localparam int QW   = (RW + 1) / 2;

  logic                 en;
  psd3_ctl_t            ctl_f, ctl_d, ctl_p, ctl_s;
  tmode_t               mode_f;
  logic signed [COORD_WIDTH-1:0] p_v [3], a_v [3], b_v [3];
  logic signed [DW-1:0] ap_f [3], ab_f [3], ap_d [3], ab_d [3];
  logic [LENW-1:0]      rem_f, den_f;
  logic [T_FRAC_BITS:0] t_d;
  logic [RW-1:0]        x_p;
  logic [QW-1:0]        root;
  logic [QW+DIST_WIDTH-1:0] dist_ext;

  assign en = !ctl_s.valid || out_if.ready;
  assign in_if.ready = en;

  assign p_v = '{in_if.p_x, in_if.p_y, in_if.p_z};
  assign a_v = '{in_if.a_x, in_if.a_y, in_if.a_z};
  assign b_v = '{in_if.b_x, in_if.b_y, in_if.b_z};

  psd3_front #(.CW(COORD_WIDTH)) u_front (
    .clk, .rst_n, .en,
    .in_valid (in_if.valid),
    .p_i      (p_v),
    .a_i      (a_v),
    .b_i      (b_v),
    .ctl_o    (ctl_f),
    .mode_o   (mode_f),
    .ap_o     (ap_f),
    .ab_o     (ab_f),
    .rem_o    (rem_f),
    .den_o    (den_f)
  );

  psd3_div #(.CW(COORD_WIDTH), .T(T_FRAC_BITS)) u_div (
    .clk, .rst_n, .en,
    .ctl_i  (ctl_f),
    .mode_i (mode_f),
    .ap_i   (ap_f),
    .ab_i   (ab_f),
    .rem_i  (rem_f),
    .den_i  (den_f),
    .ctl_o  (ctl_d),
    .ap_o   (ap_d),
    .ab_o   (ab_d),
    .t_o    (t_d)
  );

  psd3_proj #(.CW(COORD_WIDTH), .T(T_FRAC_BITS)) u_proj (
    .clk, .rst_n, .en,
    .ctl_i (ctl_d),
    .ap_i  (ap_d),
    .ab_i  (ab_d),
    .t_i   (t_d),
    .ctl_o (ctl_p),
    .x_o   (x_p)
  );

  psd3_sqrt #(.RW(RW)) u_sqrt (
    .clk, .rst_n, .en,
    .ctl_i  (ctl_p),
    .x_i    (x_p),
    .ctl_o  (ctl_s),
    .root_o (root)
  );

  assign dist_ext                  = {{DIST_WIDTH{1'b0}}, root};
  assign out_if.valid              = ctl_s.valid;
  assign out_if.distance           = dist_ext[DIST_WIDTH-1:0];
  assign out_if.segment_degenerate = ctl_s.degen;

endmodule

[sim/psd3_checker.sv]
module psd3_checker
  import psd3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  psd3_in_if   in_if,
  psd3_out_if  out_if,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TF = T_FRAC_BITS_DEF;

  typedef struct {
    logic [DIST_WIDTH-1:0] distance;
    logic                  degen;
  } seg_dist_t;

  seg_dist_t dist_q[$];

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic seg_dist_t seg_distance(longint p[3], longint a[3], longint b[3]);
    longint          ab[3];
    longint          ap[3];
    longint          dot;
    longint          len2;
    longint          d;
    longint unsigned t;
    longint unsigned m;
    logic [127:0]    acc;
    logic [127:0]    num;
    seg_dist_t       r;
    dot  = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ap[i] = p[i] - a[i];
      dot  += ap[i] * ab[i];
      len2 += ab[i] * ab[i];
    end
    r.degen = (len2 == 0);
    acc = '0;
    if (r.degen) begin
      for (int i = 0; i < 3; i++) acc += 128'(magn(ap[i])) * 128'(magn(ap[i]));
      r.distance = DIST_WIDTH'(isqrt(acc[63:0]));
    end else begin
      if (dot <= 0) begin
        t = 0;
      end else if (dot >= len2) begin
        t = 64'd1 << TF;
      end else begin
        num = 128'(dot) << TF;
        t = 64'(num / 128'(len2));
      end
      for (int i = 0; i < 3; i++) begin
        d = (ap[i] <<< TF) - ab[i] * longint'(t);
        m = magn(d);
        acc += 128'(m) * 128'(m);
      end
      num = acc >> (2 * TF);
      r.distance = DIST_WIDTH'(isqrt(num[63:0]));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    longint    p[3];
    longint    a[3];
    longint    b[3];
    seg_dist_t want;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      fails <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        p = '{longint'(in_if.p_x), longint'(in_if.p_y), longint'(in_if.p_z)};
        a = '{longint'(in_if.a_x), longint'(in_if.a_y), longint'(in_if.a_z)};
        b = '{longint'(in_if.b_x), longint'(in_if.b_y), longint'(in_if.b_z)};
        dist_q.push_back(seg_distance(p, a, b));
      end
      if (out_if.valid && out_if.ready) begin
        if (dist_q.size() == 0) begin
          $error("unexpected result transaction: distance %0d", out_if.distance);
          bad++;
        end else begin
          want = dist_q.pop_front();
          if (out_if.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_if.distance);
            bad++;
          end
          if (out_if.segment_degenerate !== want.degen) begin
            $error("segment_degenerate: expected %0d, got %0d", want.degen,
                   out_if.segment_degenerate);
            bad++;
          end
        end
      end
      if (bad != 0) fails <= fails + bad;
    end
  end

  assign pending = dist_q.size();
endmodule

[sim/point_segment_distance_3d_core_tb.sv]
module point_segment_distance_3d_core_tb;
  import psd3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int CMIN = -(2 ** (CW - 1));
  localparam int CMAX = (2 ** (CW - 1)) - 1;

  logic clk = 0;
  logic rst_n = 0;
  logic steady = 0;
  int   fails;
  int   pending;

  psd3_in_if  #(.CW(CW))         in_if ();
  psd3_out_if #(.DW(DIST_WIDTH)) out_if ();

  point_segment_distance_3d_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if)
  );

  psd3_checker chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .fails(fails), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    out_if.ready = 0;
  end

  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= 11);
  end

  task automatic send(int px, py, pz, ax, ay, az, bx, by, bz);
    if (!steady && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    {in_if.p_x, in_if.p_y, in_if.p_z} <= {CW'(px), CW'(py), CW'(pz)};
    {in_if.a_x, in_if.a_y, in_if.a_z} <= {CW'(ax), CW'(ay), CW'(az)};
    {in_if.b_x, in_if.b_y, in_if.b_z} <= {CW'(bx), CW'(by), CW'(bz)};
    in_if.valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic int coord(int sel);
    case (sel)
      0: return int'($signed(CW'($urandom)));
      1: return int'($urandom_range(4000)) - 2000;
      2: return $urandom_range(1) ? CMAX : CMIN;
      default: return int'($urandom_range(200000)) - 100000;
    endcase
  endfunction

  task automatic send_random();
    int c[9];
    int sel;
    int kind;
    sel = $urandom_range(3);
    foreach (c[i]) c[i] = ($urandom_range(9) == 0) ? coord($urandom_range(3)) : coord(sel);
    kind = $urandom_range(9);
    if (kind == 0) begin
      c[6] = c[3]; c[7] = c[4]; c[8] = c[5];
    end else if (kind == 1) begin
      c[0] = c[3]; c[1] = c[4]; c[2] = c[5];
    end else if (kind == 2) begin
      c[0] = c[6]; c[1] = c[7]; c[2] = c[8];
    end
    send(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
  endtask

  initial begin
    in_if.valid = 0;
    {in_if.p_x, in_if.p_y, in_if.p_z, in_if.a_x, in_if.a_y, in_if.a_z,
     in_if.b_x, in_if.b_y, in_if.b_z} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send(CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send(CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send(0, 0, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send(-1, -1, -1, 0, 0, 0, 1, 1, 1);
    send(-5000, 300, 0, 0, 0, 0, 1024, 0, 0);
    send(9000, -300, 7, 0, 0, 0, 1024, 0, 0);
    send(512, 700, 0, 0, 0, 0, 1024, 0, 0);
    send(1024, 0, 0, 0, 0, 0, 1024, 0, 0);
    send(0, 0, 0, 0, 0, 0, 1024, 0, 0);
    send(1, 1, 1, 0, 0, 0, 3, 0, 0);
    send(12345, -678, 90, 100, 100, 100, 100, 100, 100);
    send(CMAX, 0, CMIN, 0, 0, 0, 0, 0, 1);
    send(CMIN, CMAX, 0, CMAX, CMIN, 1, CMIN, CMAX, -1);

    for (int n = 0; n < 1535; n++) begin
      if (n == 300) steady = 1;
      if (n == 700) steady = 0;
      if (n == 900) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random();
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule

[filelist.f]
sv/psd3_pkg.sv
sv/psd3_if.sv
sv/psd3_front.sv
sv/psd3_div.sv
sv/psd3_proj.sv
sv/psd3_sqrt.sv
sv/point_segment_distance_3d_core.sv
sim/psd3_checker.sv
sim/point_segment_distance_3d_core_tb.sv
